// ----- hw/rtl/crlns_pkg.sv -----
// shared types and constants for the cache replacement state block
// word layouts of the stream ports and controller/datapath interface structs
// no dependencies
`timescale 1ns / 1ps

package crlns_pkg;

    // input word field widths and positions in s_tdata (opcode travels in s_tuser)
    localparam int SET_IDX_W  = 6;
    localparam int WAY_NUM_W  = 4;
    localparam int MASK_W     = 16;
    localparam int SET_LO     = 0;
    localparam int WAY_LO     = SET_LO + SET_IDX_W;
    localparam int EXCL_BIT   = WAY_LO + WAY_NUM_W;
    localparam int HIT_BIT    = EXCL_BIT + 1;
    localparam int COUNTS_BIT = HIT_BIT + 1;
    localparam int ELIG_LO    = COUNTS_BIT + 1;
    localparam int NOTRES_LO  = ELIG_LO + MASK_W;
    localparam int S_TDATA_W  = 48;

    // result word: victim_way, no_victim; is_victim_reply travels in m_tuser
    localparam int VICTIM_W   = 4;
    localparam int M_TDATA_W  = 8;

    // configuration register width
    localparam int MODE_W     = 2;

    // opcodes
    localparam logic OP_VICTIM = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    // replacement policies
    localparam logic [MODE_W-1:0] MODE_LRU   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_NRU   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SRRIP = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic clear_wr;   // write reset word at clearing address
        logic capture;    // take input word and read the set's state
        logic exec;       // compute, write state back, load result register
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic clear_last;   // clearing address is at the last set
        logic out_blocked;  // result register full and not being taken
    } dp_status_t;

endpackage

// ----- hw/rtl/crlns_ctrl.sv -----
// controller state machine: clearing pass, accept, execute
// depends on crlns_pkg
`timescale 1ns / 1ps

module crlns_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  crlns_pkg::dp_status_t stat,
    output crlns_pkg::dp_cmd_t    cmd
);
    import crlns_pkg::*;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next   = state_reg;
        cmd.clear_wr = 1'b0;
        cmd.capture  = 1'b0;
        cmd.exec     = 1'b0;
        s_tready     = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (stat.clear_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
                if (s_tvalid)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                cmd.exec = !stat.out_blocked;
                if (!stat.out_blocked)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // an accepted word always goes on to execution
    a_capture_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> (state_reg == ST_EXEC))
        else $error("accepted word did not move to execution");

    // execution waits while the result register is blocked
    a_exec_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC) && stat.out_blocked |=> (state_reg == ST_EXEC))
        else $error("execution left while result register blocked");

    // end of clearing pass opens the input
    a_clear_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_wr && stat.clear_last |=> s_tready)
        else $error("input not ready after clearing pass");

endmodule

// ----- hw/rtl/crlns_dpath.sv -----
// datapath: set state memory, input and result registers, policy logic
// depends on crlns_pkg
`timescale 1ns / 1ps

module crlns_dpath #(
    parameter int SET_COUNT = 64,
    parameter int NUM_WAYS  = 16,
    parameter int RRPV_BITS = 2
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [crlns_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic                                 s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [crlns_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                 m_tuser,
    input  logic                                 cfg_valid,
    input  logic [crlns_pkg::MODE_W-1:0]         cfg_data,
    input  crlns_pkg::dp_cmd_t                   cmd,
    output crlns_pkg::dp_status_t                stat
);
    import crlns_pkg::*;

    localparam int WAY_W    = $clog2(NUM_WAYS);
    localparam int SET_W    = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
    localparam int LRU_W    = NUM_WAYS * WAY_W;
    localparam int NRU_LO   = LRU_W;
    localparam int RRPV_LO  = LRU_W + NUM_WAYS;
    localparam int WORD_W   = RRPV_LO + NUM_WAYS * RRPV_BITS;
    localparam int NUM_DIST = (2 ** RRPV_BITS) - 1;
    localparam logic [RRPV_BITS-1:0] RRPV_DISTANT = {RRPV_BITS{1'b1}};
    localparam logic [RRPV_BITS-1:0] RRPV_FILL    = RRPV_DISTANT - RRPV_BITS'(1);

    // first set bit, lowest way first
    function automatic logic [WAY_W-1:0] first_way(input logic [NUM_WAYS-1:0] vec);
        logic [WAY_W-1:0] idx;
        idx = '0;
        for (int i = NUM_WAYS - 1; i >= 0; i--)
        begin
            if (vec[i])
                idx = WAY_W'(i);
        end
        return idx;
    endfunction

    // configuration and control registers
    logic [MODE_W-1:0]    policy_mode_reg;
    logic [SET_W-1:0]     clr_cnt_reg;
    logic                 out_valid_reg;

    // captured input word
    logic                 op_reg;
    logic [SET_W-1:0]     set_reg;
    logic [WAY_NUM_W-1:0] way_reg;
    logic                 excl_reg;
    logic                 hit_reg;
    logic                 counts_reg;
    logic [NUM_WAYS-1:0]  elig_reg;
    logic [NUM_WAYS-1:0]  notres_reg;

    // result register
    logic [VICTIM_W-1:0]  out_way_reg;
    logic                 out_none_reg;
    logic                 out_kind_reg;

    // memory
    logic [WORD_W-1:0]    mem [SET_COUNT];
    logic [WORD_W-1:0]    rdata_reg;
    logic                 mem_we;
    logic [SET_W-1:0]     mem_waddr;
    logic [WORD_W-1:0]    mem_wdata;
    logic [WORD_W-1:0]    reset_word;
    logic [WORD_W-1:0]    wb_word;

    // input decode
    logic [SET_IDX_W-1:0] in_set;
    logic [WAY_NUM_W-1:0] in_way;
    logic [SET_W-1:0]     set_sel;
    logic [WAY_W-1:0]     upd_way;

    // unpacked set state and policy logic
    logic [WAY_W-1:0]     pos      [NUM_WAYS];
    logic [WAY_W-1:0]     pos_upd  [NUM_WAYS];
    logic [WAY_W-1:0]     lru_wb   [NUM_WAYS];
    logic [RRPV_BITS-1:0] rrpv     [NUM_WAYS];
    logic [RRPV_BITS-1:0] aged     [NUM_WAYS];
    logic [RRPV_BITS-1:0] rrpv_wb  [NUM_WAYS];
    logic [NUM_WAYS-1:0]  nru;
    logic [NUM_WAYS-1:0]  nru_wb;
    logic [NUM_WAYS-1:0]  allowed;
    logic [NUM_WAYS-1:0]  cand;
    logic [NUM_WAYS-1:0]  lru_win;
    logic [NUM_WAYS-1:0]  rrip_win;
    logic [NUM_DIST-1:0]  ge;
    logic [RRPV_BITS-1:0] mx;
    logic [RRPV_BITS-1:0] age;
    logic [WAY_W-1:0]     cur;
    logic [WAY_W-1:0]     lru_idx;
    logic [WAY_W-1:0]     rrip_idx;
    logic [WAY_W-1:0]     nru_idx;
    logic                 nru_hit;
    logic                 nru_found;
    logic                 res_found;
    logic [WAY_W-1:0]     res_idx;
    logic [VICTIM_W-1:0]  res_way;
    logic                 res_none;
    logic                 res_kind;

    assign in_set = s_tdata[SET_LO +: SET_IDX_W];
    assign in_way = s_tdata[WAY_LO +: WAY_NUM_W];

    // set number folded into the memory depth, a constant table
    always_comb
    begin
        set_sel = '0;
        for (int v = 0; v < 2 ** SET_IDX_W; v++)
        begin
            if (in_set == SET_IDX_W'(v))
                set_sel = SET_W'(v % SET_COUNT);
        end
    end

    // accessed way folded into the way count, a constant table
    always_comb
    begin
        upd_way = '0;
        for (int v = 0; v < 2 ** WAY_NUM_W; v++)
        begin
            if (way_reg == WAY_NUM_W'(v))
                upd_way = WAY_W'(v % NUM_WAYS);
        end
    end

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_mode_reg <= MODE_LRU;
        end
        else if (cfg_valid)
        begin
            policy_mode_reg <= cfg_data;
        end
    end

    // clearing address counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clear_wr)
        begin
            if (stat.clear_last)
                clr_cnt_reg <= '0;
            else
                clr_cnt_reg <= clr_cnt_reg + SET_W'(1);
        end
    end

    assign stat.clear_last  = (clr_cnt_reg == SET_W'(SET_COUNT - 1));
    assign stat.out_blocked = out_valid_reg && !m_tready;

    // input word capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg     <= s_tuser;
            set_reg    <= set_sel;
            way_reg    <= in_way;
            excl_reg   <= s_tdata[EXCL_BIT];
            hit_reg    <= s_tdata[HIT_BIT];
            counts_reg <= s_tdata[COUNTS_BIT];
            elig_reg   <= s_tdata[ELIG_LO +: NUM_WAYS];
            notres_reg <= s_tdata[NOTRES_LO +: NUM_WAYS];
        end
    end

    // set state memory, one write and one registered read port
    assign mem_we    = cmd.clear_wr || cmd.exec;
    assign mem_waddr = cmd.clear_wr ? clr_cnt_reg : set_reg;
    assign mem_wdata = cmd.clear_wr ? reset_word : wb_word;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (cmd.capture)
            rdata_reg <= mem[set_sel];
    end

    // reset word: position equals way, bits clear, values distant
    always_comb
    begin
        reset_word = '0;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            reset_word[w * WAY_W +: WAY_W]                 = WAY_W'(w);
            reset_word[RRPV_LO + w * RRPV_BITS +: RRPV_BITS] = RRPV_DISTANT;
        end
    end

    // unpack set word and candidate ways
    always_comb
    begin
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            pos[w]     = rdata_reg[w * WAY_W +: WAY_W];
            rrpv[w]    = rdata_reg[RRPV_LO + w * RRPV_BITS +: RRPV_BITS];
            allowed[w] = elig_reg[w] && !(excl_reg && (way_reg == WAY_NUM_W'(w)));
        end
        nru = rdata_reg[NRU_LO +: NUM_WAYS];
    end

    // lru promotion of the accessed way
    always_comb
    begin
        cur = pos[upd_way];
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            if (WAY_W'(w) == upd_way)
                pos_upd[w] = '0;
            else if (pos[w] < cur)
                pos_upd[w] = pos[w] + WAY_W'(1);
            else
                pos_upd[w] = pos[w];
        end
    end

    // srrip aging: set maximum from threshold hits, then lift to distant
    always_comb
    begin
        for (int t = 1; t <= NUM_DIST; t++)
        begin
            ge[t - 1] = 1'b0;
            for (int w = 0; w < NUM_WAYS; w++)
            begin
                if (rrpv[w] >= RRPV_BITS'(t))
                    ge[t - 1] = 1'b1;
            end
        end
        mx = '0;
        for (int t = 0; t < NUM_DIST; t++)
            mx = mx + RRPV_BITS'(ge[t]);
        age = RRPV_DISTANT - mx;
        for (int w = 0; w < NUM_WAYS; w++)
            aged[w] = rrpv[w] + age;
    end

    // pairwise winner matrices: lru higher way wins ties, srrip lower way
    always_comb
    begin
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            lru_win[w]  = allowed[w];
            rrip_win[w] = allowed[w];
            for (int v = 0; v < NUM_WAYS; v++)
            begin
                if ((v != w) && allowed[v])
                begin
                    if (!((pos[v] < pos[w]) || ((pos[v] == pos[w]) && (v < w))))
                        lru_win[w] = 1'b0;
                    if (!((aged[v] < aged[w]) || ((aged[v] == aged[w]) && (v > w))))
                        rrip_win[w] = 1'b0;
                end
            end
        end
        lru_idx  = '0;
        rrip_idx = '0;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            if (lru_win[w])
                lru_idx = lru_idx | WAY_W'(w);
            if (rrip_win[w])
                rrip_idx = rrip_idx | WAY_W'(w);
        end
    end

    // nru search with not-reserved fallback
    always_comb
    begin
        cand      = allowed & ~nru;
        nru_hit   = |cand;
        nru_idx   = nru_hit ? first_way(cand) : first_way(notres_reg);
        nru_found = nru_hit || (|notres_reg);
    end

    // state write-back and result per policy
    always_comb
    begin
        lru_wb    = pos;
        nru_wb    = nru;
        rrpv_wb   = rrpv;
        res_found = 1'b0;
        res_idx   = '0;
        res_kind  = 1'b0;
        if (op_reg == OP_UPDATE)
        begin
            if (counts_reg)
            begin
                unique case (policy_mode_reg)
                    MODE_LRU:   lru_wb = pos_upd;
                    MODE_NRU:   nru_wb = nru | (NUM_WAYS'(1) << upd_way);
                    MODE_SRRIP: rrpv_wb[upd_way] = hit_reg ? '0 : RRPV_FILL;
                    default:    ;
                endcase
            end
        end
        else
        begin
            res_kind = 1'b1;
            unique case (policy_mode_reg)
                MODE_LRU:
                begin
                    res_found = |lru_win;
                    res_idx   = lru_idx;
                end
                MODE_NRU:
                begin
                    if (!nru_hit)
                        nru_wb = '0;
                    res_found = nru_found;
                    res_idx   = nru_idx;
                end
                MODE_SRRIP:
                begin
                    rrpv_wb   = aged;
                    res_found = |rrip_win;
                    res_idx   = rrip_idx;
                end
                default:
                begin
                    res_found = 1'b0;
                end
            endcase
        end
        res_none = res_kind && !res_found;
        res_way  = res_found ? VICTIM_W'(res_idx) : '0;
    end

    // pack write-back word
    always_comb
    begin
        wb_word = '0;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            wb_word[w * WAY_W +: WAY_W]                 = lru_wb[w];
            wb_word[RRPV_LO + w * RRPV_BITS +: RRPV_BITS] = rrpv_wb[w];
        end
        wb_word[NRU_LO +: NUM_WAYS] = nru_wb;
    end

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.exec)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            out_way_reg  <= res_way;
            out_none_reg <= res_none;
            out_kind_reg <= res_kind;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - VICTIM_W - 1){1'b0}}, out_none_reg, out_way_reg};
    assign m_tuser  = out_kind_reg;

    // a result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |-> !(out_valid_reg && !m_tready))
        else $error("result register overwritten");

    // execution always yields a result word
    a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> out_valid_reg)
        else $error("execution produced no result");

    // empty victim reply carries way zero
    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_none_reg |-> (out_way_reg == '0) && out_kind_reg)
        else $error("no-victim reply with nonzero way or wrong kind");

endmodule

// ----- hw/rtl/cache_replacement_lru_nru_srrip.sv -----
// top level of the cache replacement state block
// instantiates crlns_ctrl and crlns_dpath, uses crlns_pkg
`timescale 1ns / 1ps

// Per-set replacement state for a set-associative cache under true LRU, NRU or
// SRRIP, chosen by the policy register (cfg_data, 0 LRU, 1 NRU, 2 SRRIP; 3
// leaves state alone and answers every victim request with no victim). Each
// input word is either an update on access (s_tuser 1) or a victim request
// (s_tuser 0) and gives exactly one result word. Each word first has the set's
// state word read through the registered read port of the state memory, then
// all ways are evaluated in parallel, the word is written back and the result
// register is loaded. The next word is accepted while a result waits on the
// output; its execution waits until the result register is free. After reset a
// clearing pass writes the reset state into every set, during which s_tready is
// low; configuration writes are taken at any time.

module cache_replacement_lru_nru_srrip #(
    parameter int SET_COUNT = 64,
    parameter int NUM_WAYS  = 16,
    parameter int RRPV_BITS = 2
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // set_idx[5:0], way_number[9:6], exclude_enable[10], was_hit[11],
    // counts_for_policy[12], eligible_mask[28:13], not_reserved_mask[44:29]
    input  logic [crlns_pkg::S_TDATA_W-1:0] s_tdata,
    // opcode[0]
    input  logic                            s_tuser,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // victim_way[3:0], no_victim[4]
    output logic [crlns_pkg::M_TDATA_W-1:0] m_tdata,
    // is_victim_reply[0]
    output logic                            m_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // policy_mode
    input  logic [crlns_pkg::MODE_W-1:0]    cfg_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready
);
    import crlns_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t stat;

    // register writes never stall
    assign cfg_ready = 1'b1;

    // controller
    crlns_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath
    crlns_dpath #(
        .SET_COUNT (SET_COUNT),
        .NUM_WAYS  (NUM_WAYS),
        .RRPV_BITS (RRPV_BITS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
